// ----- design/sm4m_pkg.sv -----
// Package for the SM4 block cipher modes core: payload and control types,
// register codes, cipher constants and the S-box. No dependencies.
package sm4m_pkg;

  localparam int ROUND_COUNT = 32;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 64;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        first_block;
  } in_data_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_data_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KEY_WORD_ZERO  = 4'd0,
    REG_KEY_WORD_ONE   = 4'd1,
    REG_KEY_WORD_TWO   = 4'd2,
    REG_KEY_WORD_THREE = 4'd3,
    REG_CHAINING_MODE  = 4'd4,
    REG_DECRYPT_SELECT = 4'd5,
    REG_IV_HIGH        = 4'd6,
    REG_IV_LOW         = 4'd7
  } cfg_reg_t;

  localparam logic [1:0] MODE_ECB = 2'd0;
  localparam logic [1:0] MODE_CBC = 2'd1;
  localparam logic [1:0] MODE_CFB = 2'd2;

  typedef struct packed {
    logic load_key;
    logic load_block;
    logic step_key;
    logic step_round;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic key_written;
    logic out_stall;
  } dp_status_t;

  localparam logic [31:0] FK0 = 32'ha3b1bac6;
  localparam logic [31:0] FK1 = 32'h56aa3350;
  localparam logic [31:0] FK2 = 32'h677d9197;
  localparam logic [31:0] FK3 = 32'hb27022dc;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [31:0] sub_word(input logic [31:0] x);
    return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
  endfunction

  function automatic logic [31:0] ck_word(input logic [7:0] i);
    logic [7:0] base;
    begin
      base = i * 8'd28;
      return {base, base + 8'd7, base + 8'd14, base + 8'd21};
    end
  endfunction

endpackage

// ----- design/sm4m_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sm4m_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/sm4m_ctrl.sv -----
// Controller for the SM4 modes core: sequences key expansion, cipher rounds
// and result hand-off. Depends on sm4m_pkg.
module sm4m_ctrl #(
  parameter int ROUND_COUNT = sm4m_pkg::ROUND_COUNT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  sm4m_pkg::dp_status_t           status,
  output sm4m_pkg::ctrl_cmd_t            cmd,
  output logic [$clog2(ROUND_COUNT)-1:0] round_idx
);

  localparam int IW = $clog2(ROUND_COUNT);
  localparam logic [IW-1:0] LAST = IW'(ROUND_COUNT - 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_KEYEXP = 4'b0010,
    ST_ROUND  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t        state_r, state_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic          keys_ready_r, keys_ready_nxt;
  logic          in_accept;

  assign cfg_ready = (state_r == ST_IDLE);
  assign in_ready  = (state_r == ST_IDLE) && keys_ready_r && !cfg_valid;
  assign in_accept = in_valid && in_ready;
  assign round_idx = cnt_r;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    keys_ready_nxt = keys_ready_r;
    cmd            = '0;
    case (state_r)
      ST_IDLE: begin
        if (status.key_written) begin
          keys_ready_nxt = 1'b0;
        end else if (in_valid && !keys_ready_r && !cfg_valid) begin
          cmd.load_key = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = ST_KEYEXP;
        end else if (in_accept) begin
          cmd.load_block = 1'b1;
          cnt_nxt        = '0;
          state_nxt      = ST_ROUND;
        end
      end
      ST_KEYEXP: begin
        cmd.step_key = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          keys_ready_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_ROUND: begin
        cmd.step_round = 1'b1;
        cnt_nxt        = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!status.out_stall) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      keys_ready_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      keys_ready_r <= keys_ready_nxt;
    end
  end

  a_accept_starts_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == ST_ROUND) && (cnt_r == '0))
    else $error("accepted request did not start the rounds");

  a_last_round_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) && (cnt_r == LAST) |=> (state_r == ST_FINISH))
    else $error("round sequence did not end after the last round");

  a_keyexp_sets_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_KEYEXP) && (cnt_r == LAST) |=> keys_ready_r)
    else $error("key expansion ended without marking the keys ready");

  a_accept_needs_keys: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> keys_ready_r && !status.key_written)
    else $error("request accepted with stale round keys");

endmodule

// ----- design/sm4m_datapath.sv -----
// Datapath for the SM4 modes core: configuration registers, shared round
// unit, round key RAM, chaining value and output register.
// Depends on sm4m_pkg and sm4m_ram.
module sm4m_datapath #(
  parameter int ROUND_COUNT = sm4m_pkg::ROUND_COUNT
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  sm4m_pkg::in_data_t                   in_data,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [sm4m_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sm4m_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  sm4m_pkg::ctrl_cmd_t                  cmd,
  input  logic [$clog2(ROUND_COUNT)-1:0]       round_idx,
  output sm4m_pkg::dp_status_t                 status,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output sm4m_pkg::out_data_t                  out_data
);

  localparam int IW = $clog2(ROUND_COUNT);

  logic [31:0]  key_r [4];
  logic [1:0]   mode_r;
  logic         dec_r;
  logic [63:0]  iv_high_r, iv_low_r;
  logic [31:0]  words_r [4];
  logic [31:0]  words_nxt [4];
  logic [127:0] cv_r, cv_nxt;
  logic [127:0] blk_r;
  logic         out_valid_r, out_valid_nxt;
  logic [127:0] out_r, out_nxt;

  logic          cfg_we;
  logic          is_cbc, is_cfb, inverse;
  logic [127:0]  in_blk, cv_eff, load_blk, cipher_out;
  logic [31:0]   rk, mix_in, sb, tr, nw;
  logic [IW-1:0] rd_num, rd_addr;

  assign cfg_we  = cfg_valid && cfg_ready;
  assign is_cbc  = (mode_r == sm4m_pkg::MODE_CBC);
  assign is_cfb  = (mode_r == sm4m_pkg::MODE_CFB);
  assign inverse = dec_r && !is_cfb;

  assign status.key_written = cfg_we && (
    (cfg_index == sm4m_pkg::REG_KEY_WORD_ZERO) || (cfg_index == sm4m_pkg::REG_KEY_WORD_ONE) ||
    (cfg_index == sm4m_pkg::REG_KEY_WORD_TWO) || (cfg_index == sm4m_pkg::REG_KEY_WORD_THREE));
  assign status.out_stall = out_valid_r && !out_ready;

  assign rd_num  = cmd.step_round ? round_idx + 1'b1 : '0;
  assign rd_addr = inverse ? IW'(ROUND_COUNT - 1) - rd_num : rd_num;

  sm4m_ram #(
    .WIDTH (32),
    .DEPTH (ROUND_COUNT)
  ) u_rk_ram (
    .clk     (clk),
    .wr_en   (cmd.step_key),
    .wr_addr (round_idx),
    .wr_data (nw),
    .rd_addr (rd_addr),
    .rd_data (rk)
  );

  assign mix_in = words_r[1] ^ words_r[2] ^ words_r[3] ^
                  (cmd.step_key ? sm4m_pkg::ck_word(8'(round_idx)) : rk);
  assign sb = sm4m_pkg::sub_word(mix_in);
  assign tr = cmd.step_key ? (sb ^ {sb[18:0], sb[31:19]} ^ {sb[8:0], sb[31:9]})
                           : (sb ^ {sb[29:0], sb[31:30]} ^ {sb[21:0], sb[31:22]} ^
                              {sb[13:0], sb[31:14]} ^ {sb[7:0], sb[31:8]});
  assign nw = words_r[0] ^ tr;

  assign in_blk     = {in_data.block_high, in_data.block_low};
  assign cv_eff     = in_data.first_block ? {iv_high_r, iv_low_r} : cv_r;
  assign load_blk   = is_cfb ? cv_eff : (is_cbc && !dec_r) ? (in_blk ^ cv_eff) : in_blk;
  assign cipher_out = {words_r[3], words_r[2], words_r[1], words_r[0]};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      words_nxt[i] = words_r[i];
    end
    cv_nxt        = cv_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.load_key) begin
      words_nxt[0] = key_r[0] ^ sm4m_pkg::FK0;
      words_nxt[1] = key_r[1] ^ sm4m_pkg::FK1;
      words_nxt[2] = key_r[2] ^ sm4m_pkg::FK2;
      words_nxt[3] = key_r[3] ^ sm4m_pkg::FK3;
    end
    if (cmd.load_block) begin
      words_nxt[0] = load_blk[127:96];
      words_nxt[1] = load_blk[95:64];
      words_nxt[2] = load_blk[63:32];
      words_nxt[3] = load_blk[31:0];
      cv_nxt       = cv_eff;
    end
    if (cmd.step_key || cmd.step_round) begin
      words_nxt[0] = words_r[1];
      words_nxt[1] = words_r[2];
      words_nxt[2] = words_r[3];
      words_nxt[3] = nw;
    end
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
      if (is_cbc) begin
        out_nxt = dec_r ? (cipher_out ^ cv_r) : cipher_out;
        cv_nxt  = dec_r ? blk_r : cipher_out;
      end else if (is_cfb) begin
        out_nxt = cipher_out ^ blk_r;
        cv_nxt  = dec_r ? blk_r : (cipher_out ^ blk_r);
      end else begin
        out_nxt = cipher_out;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        key_r[i] <= '0;
      end
      mode_r      <= sm4m_pkg::MODE_ECB;
      dec_r       <= 1'b0;
      iv_high_r   <= '0;
      iv_low_r    <= '0;
      cv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sm4m_pkg::REG_KEY_WORD_ZERO:  key_r[0]  <= cfg_data[31:0];
          sm4m_pkg::REG_KEY_WORD_ONE:   key_r[1]  <= cfg_data[31:0];
          sm4m_pkg::REG_KEY_WORD_TWO:   key_r[2]  <= cfg_data[31:0];
          sm4m_pkg::REG_KEY_WORD_THREE: key_r[3]  <= cfg_data[31:0];
          sm4m_pkg::REG_CHAINING_MODE:  mode_r    <= cfg_data[1:0];
          sm4m_pkg::REG_DECRYPT_SELECT: dec_r     <= cfg_data[0];
          sm4m_pkg::REG_IV_HIGH:        iv_high_r <= cfg_data;
          sm4m_pkg::REG_IV_LOW:         iv_low_r  <= cfg_data;
          default: begin
          end
        endcase
      end
      cv_r        <= cv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      words_r[i] <= words_nxt[i];
    end
    out_r <= out_nxt;
    if (cmd.load_block) begin
      blk_r <= in_blk;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_data.result_high = out_r[127:64];
  assign out_data.result_low  = out_r[63:0];

endmodule

// ----- design/sm4_block_cipher_modes_core.sv -----
// Top level of the SM4 block cipher core with ECB, CBC and CFB chaining.
// Depends on sm4m_pkg, sm4m_ctrl, sm4m_datapath and sm4m_ram.
//
//   Channel   Ports                                   Moves
//   input     in_valid, in_ready, in_data             one 128-bit block request
//   result    out_valid, out_ready, out_data          one 128-bit result
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data   one register write
//
// A block is loaded in its accept cycle, runs its rounds on the single shared round
// unit, and is written to the result register in the output cycle.
// After a key write, the next request first runs the key schedule through the same
// round unit into the round key RAM.
// Reset is synchronous and clears key, mode, direction, IV, chaining value and out_valid.
// A held result stalls the core in its output cycle until out_ready is seen.
module sm4_block_cipher_modes_core #(
  parameter int ROUND_COUNT = sm4m_pkg::ROUND_COUNT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  sm4m_pkg::in_data_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output sm4m_pkg::out_data_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sm4m_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sm4m_pkg::CFG_DATA_W-1:0]  cfg_data
);

  sm4m_pkg::ctrl_cmd_t            cmd;
  sm4m_pkg::dp_status_t           status;
  logic [$clog2(ROUND_COUNT)-1:0] round_idx;

  sm4m_ctrl #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .status    (status),
    .cmd       (cmd),
    .round_idx (round_idx)
  );

  sm4m_datapath #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .round_idx (round_idx),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for sm4_block_cipher_modes_core: a directed table of blocks and
// register settings, then chained random messages, checked against an SM4 ECB/CBC/CFB
// predictor in the testbench; typed rows use the table. Depends on sm4m_pkg and the core.
module tb;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int MAX_GAP      = 20;
  localparam int DRAIN_CYCLES = 80;
  localparam int NUM_ROWS     = 20;
  localparam int SEGMENTS     = 6;
  localparam int SEGMENT_LEN  = 105;
  localparam int ROUND_COUNT  = sm4m_pkg::ROUND_COUNT;

  localparam logic [sm4m_pkg::CFG_INDEX_W-1:0] REG_SPARE = 4'hf;
  localparam logic [1:0] MODE_ECB       = sm4m_pkg::MODE_ECB;
  localparam logic [1:0] MODE_CBC       = sm4m_pkg::MODE_CBC;
  localparam logic [1:0] MODE_CFB       = sm4m_pkg::MODE_CFB;
  localparam logic [1:0] MODE_ECB_ALIAS = 2'd3;
  localparam logic DIR_ENCRYPT = 1'b0;
  localparam logic DIR_DECRYPT = 1'b1;

  localparam logic [127:0] ZERO_BLOCK = '0;
  localparam logic [127:0] ONES_BLOCK = '1;
  localparam logic [127:0] STD_KEY    = 128'h0123456789abcdeffedcba9876543210;
  localparam logic [127:0] STD_CIPHER = 128'h681edf34d206965e86b3e94f536e4246;
  localparam logic [127:0] IV_RAMP    = 128'h000102030405060708090a0b0c0d0e0f;
  localparam logic [127:0] ALT_BLOCK  = 128'h5555aaaa5555aaaa3c3c3c3cc3c3c3c3;

  typedef struct packed {
    logic [127:0] key;
    logic [1:0]   mode;
    logic         dir;
    logic [127:0] iv;
    logic [127:0] block;
    logic         first;
    logic         typed;
    logic [127:0] want;
  } vector_t;

  localparam vector_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{ZERO_BLOCK, MODE_ECB, DIR_ENCRYPT, ZERO_BLOCK, ZERO_BLOCK, 1'b0, 1'b0, ZERO_BLOCK},
    '{ZERO_BLOCK, MODE_ECB, DIR_ENCRYPT, ZERO_BLOCK, ONES_BLOCK, 1'b0, 1'b0, ZERO_BLOCK},
    '{ZERO_BLOCK, MODE_CFB, DIR_ENCRYPT, ZERO_BLOCK, ALT_BLOCK, 1'b0, 1'b0, ZERO_BLOCK},
    '{STD_KEY, MODE_ECB, DIR_ENCRYPT, ZERO_BLOCK, STD_KEY, 1'b0, 1'b1, STD_CIPHER},
    '{STD_KEY, MODE_ECB, DIR_DECRYPT, ZERO_BLOCK, STD_CIPHER, 1'b0, 1'b1, STD_KEY},
    '{STD_KEY, MODE_CBC, DIR_ENCRYPT, IV_RAMP, ONES_BLOCK, 1'b1, 1'b0, ZERO_BLOCK},
    '{STD_KEY, MODE_CBC, DIR_ENCRYPT, IV_RAMP, ZERO_BLOCK, 1'b0, 1'b0, ZERO_BLOCK},
    '{STD_KEY, MODE_CBC, DIR_DECRYPT, IV_RAMP, STD_CIPHER, 1'b1, 1'b0, ZERO_BLOCK},
    '{STD_KEY, MODE_CBC, DIR_DECRYPT, IV_RAMP, ONES_BLOCK, 1'b0, 1'b0, ZERO_BLOCK},
    '{STD_KEY, MODE_CFB, DIR_ENCRYPT, IV_RAMP, ZERO_BLOCK, 1'b1, 1'b0, ZERO_BLOCK},
    '{STD_KEY, MODE_CFB, DIR_ENCRYPT, IV_RAMP, ALT_BLOCK, 1'b0, 1'b0, ZERO_BLOCK},
    '{STD_KEY, MODE_CFB, DIR_DECRYPT, IV_RAMP, ONES_BLOCK, 1'b1, 1'b0, ZERO_BLOCK},
    '{STD_KEY, MODE_CFB, DIR_DECRYPT, IV_RAMP, STD_KEY, 1'b0, 1'b0, ZERO_BLOCK},
    '{STD_KEY, MODE_ECB_ALIAS, DIR_ENCRYPT, IV_RAMP, STD_KEY, 1'b1, 1'b1, STD_CIPHER},
    '{STD_KEY, MODE_ECB_ALIAS, DIR_DECRYPT, IV_RAMP, STD_CIPHER, 1'b0, 1'b1, STD_KEY},
    '{ONES_BLOCK, MODE_CBC, DIR_ENCRYPT, ONES_BLOCK, ONES_BLOCK, 1'b1, 1'b0, ZERO_BLOCK},
    '{ONES_BLOCK, MODE_CFB, DIR_DECRYPT, ONES_BLOCK, ZERO_BLOCK, 1'b1, 1'b0, ZERO_BLOCK},
    '{ONES_BLOCK, MODE_ECB, DIR_DECRYPT, ONES_BLOCK, ONES_BLOCK, 1'b0, 1'b0, ZERO_BLOCK},
    '{ZERO_BLOCK, MODE_ECB, DIR_ENCRYPT, ONES_BLOCK, ZERO_BLOCK, 1'b1, 1'b0, ZERO_BLOCK},
    '{ZERO_BLOCK, MODE_CBC, DIR_ENCRYPT, ZERO_BLOCK, ZERO_BLOCK, 1'b1, 1'b0, ZERO_BLOCK}
  };

  logic                                 clk       = 1'b0;
  logic                                 rst_n     = 1'b0;
  logic                                 in_valid  = 1'b0;
  logic                                 in_ready;
  sm4m_pkg::in_data_t                   in_data   = '0;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  sm4m_pkg::out_data_t                  out_data;
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic [sm4m_pkg::CFG_INDEX_W-1:0]     cfg_index = '0;
  logic [sm4m_pkg::CFG_DATA_W-1:0]      cfg_data  = '0;

  logic [31:0]  key_reg [4];
  logic [1:0]   mode_reg;
  logic         decrypt_reg;
  logic [63:0]  iv_high_reg;
  logic [63:0]  iv_low_reg;
  logic [31:0]  round_keys [ROUND_COUNT];
  logic         keys_valid;
  logic [127:0] chain_block;

  sm4m_pkg::out_data_t expected_blocks [$];
  int  error_count   = 0;
  int  cycle_count   = 0;
  int  send_idle_pct = 35;
  int  recv_idle_pct = 62;
  bit  sender_active = 1'b0;

  sm4_block_cipher_modes_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] x);
    return {sm4m_pkg::SBOX[x[31:24]], sm4m_pkg::SBOX[x[23:16]],
            sm4m_pkg::SBOX[x[15:8]], sm4m_pkg::SBOX[x[7:0]]};
  endfunction

  function automatic logic [31:0] round_mix(input logic [31:0] x);
    logic [31:0] b;
    b = sbox_word(x);
    return b ^ rol32(b, 2) ^ rol32(b, 10) ^ rol32(b, 18) ^ rol32(b, 24);
  endfunction

  function automatic logic [31:0] key_mix(input logic [31:0] x);
    logic [31:0] b;
    b = sbox_word(x);
    return b ^ rol32(b, 13) ^ rol32(b, 23);
  endfunction

  function automatic logic [31:0] ck_constant(input int i);
    logic [31:0] v;
    v = '0;
    for (int j = 0; j < 4; j++) v = {v[23:0], 8'((4 * i + j) * 7)};
    return v;
  endfunction

  function automatic void expand_round_keys();
    logic [31:0] k [4];
    logic [31:0] nk;
    k[0] = key_reg[0] ^ sm4m_pkg::FK0;
    k[1] = key_reg[1] ^ sm4m_pkg::FK1;
    k[2] = key_reg[2] ^ sm4m_pkg::FK2;
    k[3] = key_reg[3] ^ sm4m_pkg::FK3;
    for (int i = 0; i < ROUND_COUNT; i++) begin
      nk = k[0] ^ key_mix(k[1] ^ k[2] ^ k[3] ^ ck_constant(i));
      k[0] = k[1];
      k[1] = k[2];
      k[2] = k[3];
      k[3] = nk;
      round_keys[i] = nk;
    end
    keys_valid = 1'b1;
  endfunction

  function automatic logic [127:0] sm4_crypt(input logic [127:0] blk, input logic inverse);
    logic [31:0] w [4];
    logic [31:0] rk;
    logic [31:0] nw;
    w[0] = blk[127:96];
    w[1] = blk[95:64];
    w[2] = blk[63:32];
    w[3] = blk[31:0];
    for (int r = 0; r < ROUND_COUNT; r++) begin
      rk = inverse ? round_keys[ROUND_COUNT - 1 - r] : round_keys[r];
      nw = w[0] ^ round_mix(w[1] ^ w[2] ^ w[3] ^ rk);
      w[0] = w[1];
      w[1] = w[2];
      w[2] = w[3];
      w[3] = nw;
    end
    return {w[3], w[2], w[1], w[0]};
  endfunction

  function automatic sm4m_pkg::out_data_t predict_cipher_result(input sm4m_pkg::in_data_t req);
    logic [127:0] din;
    logic [127:0] dout;
    din = {req.block_high, req.block_low};
    if (!keys_valid) expand_round_keys();
    if (req.first_block) chain_block = {iv_high_reg, iv_low_reg};
    case (mode_reg)
      MODE_CBC: begin
        if (decrypt_reg == DIR_DECRYPT) begin
          dout = sm4_crypt(din, DIR_DECRYPT) ^ chain_block;
          chain_block = din;
        end else begin
          dout = sm4_crypt(din ^ chain_block, DIR_ENCRYPT);
          chain_block = dout;
        end
      end
      MODE_CFB: begin
        dout = sm4_crypt(chain_block, DIR_ENCRYPT) ^ din;
        chain_block = (decrypt_reg == DIR_DECRYPT) ? din : dout;
      end
      default: dout = sm4_crypt(din, decrypt_reg);
    endcase
    return dout;
  endfunction

  function automatic void report_mismatch(input string field, input logic [63:0] want,
                                          input logic [63:0] got);
    error_count++;
    if (error_count <= 10) $display("mismatch on %s: expected %h, got %h", field, want, got);
  endfunction

  always @(posedge clk) begin : check_results
    sm4m_pkg::out_data_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_blocks.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("result %h %h with no request outstanding",
                   out_data.result_high, out_data.result_low);
      end else begin
        want = expected_blocks.pop_front();
        if (out_data.result_high !== want.result_high)
          report_mismatch("result_high", want.result_high, out_data.result_high);
        if (out_data.result_low !== want.result_low)
          report_mismatch("result_low", want.result_low, out_data.result_low);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sm4_block_cipher_modes_core test failed");
    $finish;
  end

  task automatic push_block(input sm4m_pkg::in_data_t req, input logic typed,
                            input logic [127:0] want);
    int gap;
    sm4m_pkg::out_data_t pred;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      if (sender_active) in_valid <= 1'b0;
      sender_active = 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    sender_active = 1'b1;
    do @(posedge clk); while (!in_ready);
    pred = predict_cipher_result(req);
    if (typed) pred = want;
    expected_blocks.push_back(pred);
  endtask

  task automatic wait_drained();
    if (sender_active) in_valid <= 1'b0;
    sender_active = 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [sm4m_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      sm4m_pkg::REG_KEY_WORD_ZERO:  begin key_reg[0] = value[31:0]; keys_valid = 1'b0; end
      sm4m_pkg::REG_KEY_WORD_ONE:   begin key_reg[1] = value[31:0]; keys_valid = 1'b0; end
      sm4m_pkg::REG_KEY_WORD_TWO:   begin key_reg[2] = value[31:0]; keys_valid = 1'b0; end
      sm4m_pkg::REG_KEY_WORD_THREE: begin key_reg[3] = value[31:0]; keys_valid = 1'b0; end
      sm4m_pkg::REG_CHAINING_MODE:  mode_reg = value[1:0];
      sm4m_pkg::REG_DECRYPT_SELECT: decrypt_reg = value[0];
      sm4m_pkg::REG_IV_HIGH:        iv_high_reg = value;
      sm4m_pkg::REG_IV_LOW:         iv_low_reg = value;
      default: ;
    endcase
  endtask

  task automatic program_settings(input logic [127:0] key, input logic [1:0] mode,
                                  input logic dir, input logic [127:0] iv);
    if (key != {key_reg[0], key_reg[1], key_reg[2], key_reg[3]} || mode != mode_reg ||
        dir != decrypt_reg || iv != {iv_high_reg, iv_low_reg}) begin
      wait_drained();
      if (key[127:96] != key_reg[0])
        write_register(sm4m_pkg::REG_KEY_WORD_ZERO, {$urandom, key[127:96]});
      if (key[95:64] != key_reg[1])
        write_register(sm4m_pkg::REG_KEY_WORD_ONE, {$urandom, key[95:64]});
      if (key[63:32] != key_reg[2])
        write_register(sm4m_pkg::REG_KEY_WORD_TWO, {$urandom, key[63:32]});
      if (key[31:0] != key_reg[3])
        write_register(sm4m_pkg::REG_KEY_WORD_THREE, {$urandom, key[31:0]});
      if (mode != mode_reg)
        write_register(sm4m_pkg::REG_CHAINING_MODE, {$urandom, 30'($urandom), mode});
      if (dir != decrypt_reg)
        write_register(sm4m_pkg::REG_DECRYPT_SELECT, {$urandom, 31'($urandom), dir});
      if (iv[127:64] != iv_high_reg) write_register(sm4m_pkg::REG_IV_HIGH, iv[127:64]);
      if (iv[63:0] != iv_low_reg) write_register(sm4m_pkg::REG_IV_LOW, iv[63:0]);
      cfg_valid <= 1'b0;
    end
  endtask

  function automatic logic [127:0] random_block();
    case ($urandom_range(15))
      0:       return ZERO_BLOCK;
      1:       return ONES_BLOCK;
      default: return {$urandom, $urandom, $urandom, $urandom};
    endcase
  endfunction

  task automatic run_segment(input int item_target);
    logic [127:0]       key;
    logic [127:0]       iv;
    logic [127:0]       blk;
    logic               first;
    sm4m_pkg::in_data_t req;
    int                 sent;
    int                 msg_len;
    int                 pause_at;
    case ($urandom_range(7))
      0:       key = ZERO_BLOCK;
      1:       key = ONES_BLOCK;
      2, 3:    key = {key_reg[0], key_reg[1], key_reg[2], key_reg[3]};
      default: key = {$urandom, $urandom, $urandom, $urandom};
    endcase
    iv = random_block();
    program_settings(key, 2'($urandom_range(3)), 1'($urandom_range(1)), iv);
    pause_at = $urandom_range(item_target, 1);
    sent = 0;
    while (sent < item_target) begin
      msg_len = $urandom_range(12, 1);
      for (int b = 0; b < msg_len && sent < item_target; b++) begin
        first = (b == 0);
        if ($urandom_range(19) == 0) first = ~first;
        blk = random_block();
        req.block_high  = blk[127:64];
        req.block_low   = blk[63:0];
        req.first_block = first;
        push_block(req, 1'b0, ZERO_BLOCK);
        sent++;
        if (sent == pause_at) wait_drained();
      end
    end
  endtask

  initial begin
    sm4m_pkg::in_data_t req;
    key_reg     = '{default: '0};
    mode_reg    = MODE_ECB;
    decrypt_reg = DIR_ENCRYPT;
    iv_high_reg = '0;
    iv_low_reg  = '0;
    keys_valid  = 1'b0;
    chain_block = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < NUM_ROWS; r++) begin
      program_settings(DIRECTED_ROWS[r].key, DIRECTED_ROWS[r].mode, DIRECTED_ROWS[r].dir,
                       DIRECTED_ROWS[r].iv);
      req.block_high  = DIRECTED_ROWS[r].block[127:64];
      req.block_low   = DIRECTED_ROWS[r].block[63:0];
      req.first_block = DIRECTED_ROWS[r].first;
      push_block(req, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
    end

    // A write to an unmapped index must leave every register alone.
    wait_drained();
    write_register(REG_SPARE, {$urandom, $urandom});
    cfg_valid <= 1'b0;
    @(posedge clk);

    for (int regime = 0; regime < 3; regime++) begin
      case (regime)
        0:       begin send_idle_pct = 35; recv_idle_pct = 62; end
        1:       begin send_idle_pct = 62; recv_idle_pct = 35; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      for (int s = 0; s < SEGMENTS; s++) run_segment(SEGMENT_LEN);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_blocks.size() == 0) begin
      $display("sm4_block_cipher_modes_core test passed");
    end else begin
      $display("sm4_block_cipher_modes_core test failed");
    end
    $finish;
  end

endmodule
